// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the port-level checker of the project.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/slis_pkg.sv -----
// Package for the source line identifier scanner.
// Character constants, classification functions, FSM and control types; no dependencies.
`timescale 1ns / 1ps

package slis_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [1:0] SKIP_LEN = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SHOW = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic idx_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic last;
  } dp_status_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_letter(c) || (c inside {[8'h30:8'h39], CH_UNDERSCORE, CH_DOT});
  endfunction

endpackage

// ----- rtl/core/slis_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module slis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/slis_datapath.sv -----
// Datapath of the scanner: comment/string/char filters, identifier collection,
// identifier buffer and emission index. Depends on slis_pkg and slis_ram.
`timescale 1ns / 1ps

module slis_datapath #(
  parameter int IDENT_MAX = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             in_char_code,
  input  logic                   in_line_end,
  input  slis_pkg::dp_cmd_t      cmd,
  output slis_pkg::dp_status_t   sts,
  output logic [7:0]             out_ident_char,
  output logic                   out_ident_last
);

  import slis_pkg::*;

  localparam int AW = (IDENT_MAX > 1) ? $clog2(IDENT_MAX) : 1;
  localparam int LW = $clog2(IDENT_MAX + 1);

  logic          held_v_r, held_v_nxt;
  logic          cut_r, cut_nxt;
  logic          str_r, str_nxt;
  logic [1:0]    skip_r, skip_nxt;
  logic          in_id_r, in_id_nxt;
  logic          dot_r, dot_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] emit_len_r, emit_len_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          scan_flush;
  logic          flush;
  logic          emit;

  always_comb begin
    held_v_nxt   = held_v_r;
    cut_nxt      = cut_r;
    str_nxt      = str_r;
    skip_nxt     = skip_r;
    in_id_nxt    = in_id_r;
    dot_nxt      = dot_r;
    len_nxt      = len_r;
    emit_len_nxt = emit_len_r;
    idx_nxt      = idx_r;
    wr_en        = 1'b0;
    wr_addr      = len_r[AW-1:0];
    scan_flush   = 1'b0;
    flush        = 1'b0;
    emit         = 1'b0;

    if (cmd.accept) begin
      if (!cut_r) begin
        if (in_char_code == CH_SLASH && held_v_r) begin
          cut_nxt    = 1'b1;
          held_v_nxt = 1'b0;
        end else begin
          held_v_nxt = (in_char_code == CH_SLASH);
          if (str_r) begin
            if (in_char_code == CH_DQUOTE) begin
              str_nxt = 1'b0;
            end
          end else if (in_char_code == CH_DQUOTE) begin
            str_nxt = 1'b1;
          end else if (skip_r != 2'd0) begin
            skip_nxt = skip_r - 2'd1;
          end else if (in_char_code == CH_SQUOTE) begin
            skip_nxt = SKIP_LEN;
          end else if (!in_id_r) begin
            if (is_letter(in_char_code)) begin
              in_id_nxt = 1'b1;
              dot_nxt   = 1'b0;
              wr_en     = 1'b1;
              wr_addr   = '0;
              len_nxt   = LW'(1);
            end
          end else if (!is_ident_char(in_char_code)) begin
            scan_flush = 1'b1;
          end else if (in_char_code == CH_DOT && !dot_r) begin
            dot_nxt = 1'b1;
            len_nxt = '0;
          end else if (len_r < LW'(IDENT_MAX)) begin
            wr_en   = 1'b1;
            wr_addr = len_r[AW-1:0];
            len_nxt = len_r + LW'(1);
          end
        end
      end

      flush = scan_flush || in_line_end;
      emit  = flush && in_id_nxt && (len_nxt != '0);
      if (emit) begin
        emit_len_nxt = len_nxt;
        idx_nxt      = '0;
      end
      if (flush) begin
        in_id_nxt = 1'b0;
        dot_nxt   = 1'b0;
        len_nxt   = '0;
      end
      if (in_line_end) begin
        held_v_nxt = 1'b0;
        cut_nxt    = 1'b0;
        str_nxt    = 1'b0;
        skip_nxt   = '0;
      end
    end

    if (cmd.idx_inc) begin
      idx_nxt = idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
      cut_r    <= 1'b0;
      str_r    <= 1'b0;
      skip_r   <= '0;
      in_id_r  <= 1'b0;
      dot_r    <= 1'b0;
      len_r    <= '0;
    end else begin
      held_v_r <= held_v_nxt;
      cut_r    <= cut_nxt;
      str_r    <= str_nxt;
      skip_r   <= skip_nxt;
      in_id_r  <= in_id_nxt;
      dot_r    <= dot_nxt;
      len_r    <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_len_r <= emit_len_nxt;
    idx_r      <= idx_nxt;
  end

  assign rd_addr = cmd.idx_inc ? (idx_r + AW'(1)) : idx_r;

  slis_ram #(
    .WIDTH(8),
    .DEPTH(IDENT_MAX)
  ) u_buf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_char_code),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(out_ident_char)
  );

  assign sts.emit_req   = emit;
  assign sts.last       = ((LW'(idx_r) + LW'(1)) == emit_len_r);
  assign out_ident_last = sts.last;

endmodule

// ----- rtl/core/slis_ctrl.sv -----
// Controller FSM of the scanner: input transfers, buffer reads, result transfers.
// Depends on slis_pkg.
`timescale 1ns / 1ps

module slis_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  slis_pkg::dp_status_t sts,
  output slis_pkg::dp_cmd_t    cmd
);

  import slis_pkg::*;

  state_t st_r, st_nxt;

  always_comb begin
    st_nxt      = st_r;
    cmd.accept  = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.idx_inc = 1'b0;
    case (st_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.emit_req) begin
          st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        st_nxt    = ST_SHOW;
      end
      ST_SHOW: begin
        if (!out_stall) begin
          if (sts.last) begin
            st_nxt = ST_IDLE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_SHOW);

endmodule

// ----- rtl/core/source_line_identifier_scanner.sv -----
// Source line identifier scanner, top level.
// Depends on slis_pkg, slis_ctrl, slis_datapath (and slis_ram through it).
//
// Takes one character per transfer with a line-end flag, strips "//" comments,
// double-quoted runs and character constants, and streams out the identifiers
// that remain, one character per result transfer with a last flag on the final
// character. While no identifier is ready the block takes one character per
// cycle. An identifier is read back from the identifier buffer (one registered
// read port) while the input is stalled, until its last character is taken.
`timescale 1ns / 1ps

module source_line_identifier_scanner #(
  parameter int IDENT_MAX = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_ident_char,
  output logic       out_ident_last
);

  import slis_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  slis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  slis_datapath #(
    .IDENT_MAX(IDENT_MAX)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_char_code  (in_char_code),
    .in_line_end   (in_line_end),
    .cmd           (cmd),
    .sts           (sts),
    .out_ident_char(out_ident_char),
    .out_ident_last(out_ident_last)
  );

endmodule

// ----- rtl/core/slis_checker.sv -----
// Port-level checker for the scanner and its bind to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slis_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_char_code,
  input logic       in_line_end,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_ident_char,
  input logic       out_ident_last
);

  // No input transfer while a result is on offer.
  `ASSERT_IMPL(a_no_overlap, out_valid, in_stall)

  // A stalled result holds.
  `ASSERT_NEXT(a_hold, (out_valid && out_stall), (out_valid && $stable(out_ident_char) && $stable(out_ident_last)))

  // An input transfer is never followed directly by a result.
  `ASSERT_NEXT(a_read_gap, (in_valid && !in_stall), !out_valid)

  // The last character of an identifier closes the burst.
  `ASSERT_NEXT(a_burst_end, (out_valid && !out_stall && out_ident_last), !out_valid)

endmodule

bind source_line_identifier_scanner slis_checker u_slis_checker (.*);

// ----- dv/tb.sv -----
// Self-checking testbench for source_line_identifier_scanner.
// Streams source lines through the scanner and checks each identifier character against a
// built-in predictor of the comment, string and character-constant filters; needs slis_pkg.
`timescale 1ns / 1ps

module tb;
  import slis_pkg::*;

  localparam int IDENT_MAX   = 32;
  localparam int N_RANDOM    = 370;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_AT_ITEM = 150;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [7:0] code;
    logic       eol;
  } src_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ident_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code = 8'h00;
  logic       in_line_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_ident_char;
  logic       out_ident_last;

  src_item_t   src_q[$];
  logic [7:0]  line_buf[$];
  ident_beat_t ident_due[$];

  int unsigned cycle_cnt = 0;
  int          mismatches = 0;
  int          n_sent = 0;
  int          src_gap = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  // predictor state
  bit         p_slash_held, p_cut, p_quoted, p_in_word, p_dot;
  bit [1:0]   p_skip;
  logic [7:0] p_word[IDENT_MAX];
  int         p_len;

  source_line_identifier_scanner #(.IDENT_MAX(IDENT_MAX)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_code  (in_char_code),
    .in_line_end   (in_line_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ident_char(out_ident_char),
    .out_ident_last(out_ident_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit char_is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit char_is_word(logic [7:0] c);
    return char_is_alpha(c) || (c >= "0" && c <= "9") || c == CH_UNDERSCORE || c == CH_DOT;
  endfunction

  task automatic emit_word();
    if (p_in_word)
      for (int i = 0; i < p_len; i++)
        ident_due.push_back('{ch: p_word[i], last: (i + 1 == p_len)});
    p_in_word = 1'b0;
    p_dot = 1'b0;
    p_len = 0;
  endtask

  task automatic collect_word(logic [7:0] c);
    if (!p_in_word) begin
      if (char_is_alpha(c)) begin
        p_in_word = 1'b1;
        p_dot = 1'b0;
        p_word[0] = c;
        p_len = 1;
      end
    end else if (!char_is_word(c)) begin
      emit_word();
    end else if (c == CH_DOT && !p_dot) begin
      p_dot = 1'b1;
      p_len = 0;
    end else if (p_len < IDENT_MAX) begin
      p_word[p_len] = c;
      p_len++;
    end
  endtask

  task automatic predict_char(logic [7:0] c, logic eol);
    if (!p_cut) begin
      if (c == CH_SLASH && p_slash_held) begin
        p_cut = 1'b1;
        p_slash_held = 1'b0;
      end else begin
        if (p_quoted) begin
          if (c == CH_DQUOTE) p_quoted = 1'b0;
        end else if (c == CH_DQUOTE) begin
          p_quoted = 1'b1;
        end else if (p_skip > 0) begin
          p_skip = p_skip - 2'd1;
        end else if (c == CH_SQUOTE) begin
          p_skip = SKIP_LEN;
        end else begin
          collect_word(c);
        end
        p_slash_held = (c == CH_SLASH);
      end
    end
    if (eol) begin
      emit_word();
      p_slash_held = 1'b0;
      p_cut = 1'b0;
      p_quoted = 1'b0;
      p_skip = 2'd0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got_c, input logic got_l,
                                 input logic [7:0] want_c, input logic want_l);
    $display("tb: mismatch (%s) at cycle %0d: got %h/%b want %h/%b",
             what, cycle_cnt, got_c, got_l, want_c, want_l);
    mismatches++;
  endtask

  // mostly short gaps, a few long ones; calm windows with none at all
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (cycle_cnt[9:8] == 2'b00) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 69);
    if (r < 52) return rand_alpha();
    if (r < 62) return 8'("0" + r - 52);
    if (r < 66) return CH_UNDERSCORE;
    return CH_DOT;
  endfunction

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic commit_line();
    for (int i = 0; i < line_buf.size(); i++)
      src_q.push_back('{code: line_buf[i], eol: (i + 1 == line_buf.size())});
    line_buf.delete();
  endtask

  task automatic build_random_line();
    int n_tok, kind, len;
    n_tok = $urandom_range(1, 8);
    for (int t = 0; t < n_tok; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 40) : $urandom_range(0, 6);
        line_buf.push_back(rand_alpha());
        for (int i = 0; i < len; i++) line_buf.push_back(rand_word_char());
      end else if (kind < 55) begin
        case ($urandom_range(0, 5))
          0: put_text(" ");
          1: put_text("(");
          2: put_text(", ");
          3: put_text(";");
          4: put_text(" = ");
          default: put_text("+");
        endcase
      end else if (kind < 63) begin
        line_buf.push_back(CH_DQUOTE);
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) line_buf.push_back(rand_word_char());
        if ($urandom_range(0, 4) != 0) line_buf.push_back(CH_DQUOTE);
      end else if (kind < 71) begin
        line_buf.push_back(CH_SQUOTE);
        line_buf.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 3) != 0) line_buf.push_back(CH_SQUOTE);
      end else if (kind < 77) begin
        put_text("//");
        len = $urandom_range(0, 5);
        for (int i = 0; i < len; i++) line_buf.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 85) begin
        if ($urandom_range(0, 1)) line_buf.push_back(CH_SLASH);
        else line_buf.push_back(8'("0" + $urandom_range(0, 9)));
      end else begin
        line_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
    commit_line();
  endtask

  initial begin
    int n_directed;
    // dot, underscore, digit, high byte, lone slash at line end
    put_text("ab.c_9");
    line_buf.push_back(8'hFF);
    put_text("Z/");
    commit_line();
    put_text("q//w");
    commit_line();
    // string inside an identifier, char constant cut by line end
    put_text("m\"n\"p'");
    commit_line();
    // empty after the dot, unpaired quote
    put_text("a.\"z");
    commit_line();
    put_text("'xyz");
    commit_line();
    n_directed = src_q.size();
    while (src_q.size() < n_directed + N_RANDOM) build_random_line();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (src_q.size() != 0 || in_valid) @(posedge clk);
    while (ident_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin : drv
    src_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_char(in_char_code, in_line_end);
        n_sent <= n_sent + 1;
      end
      if (src_gap > 0) begin
        in_valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (src_q.size() != 0) begin
        item = src_q.pop_front();
        in_valid <= 1'b1;
        in_char_code <= item.code;
        in_line_end <= item.eol;
        src_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off once enough input has been sent
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_sent >= HOLD_AT_ITEM) begin
      hold_done <= 1'b1;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    ident_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (ident_due.size() == 0) begin
        report_mismatch("unexpected transfer", out_ident_char, out_ident_last, 8'h00, 1'b0);
      end else begin
        exp_beat = ident_due.pop_front();
        if (out_ident_char !== exp_beat.ch)
          report_mismatch("ident_char", out_ident_char, out_ident_last,
                          exp_beat.ch, exp_beat.last);
        if (out_ident_last !== exp_beat.last)
          report_mismatch("ident_last", out_ident_char, out_ident_last,
                          exp_beat.ch, exp_beat.last);
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/slis_pkg.sv
rtl/core/slis_ram.sv
rtl/core/slis_datapath.sv
rtl/core/slis_ctrl.sv
rtl/core/source_line_identifier_scanner.sv
rtl/core/slis_checker.sv
dv/tb.sv
